// File: rtl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared constants and types of the command framer: character codes, CRC
// polynomial, queue sizing, register map and the queue entry.
// ----------------------------------------------------------------------------
package cfr_pkg;

	localparam logic [7:0]  CHAR_SPACE = 8'h20;
	localparam logic [7:0]  CHAR_COLON = 8'h3A;
	localparam logic [7:0]  CHAR_CR    = 8'h0D;

	localparam logic [15:0] CRC_POLY   = 16'hA001;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int  PADDR_W     = 3;
	localparam int  PDATA_W     = 32;
	localparam logic REG_ADD_CRC = 1'b0;

	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        hex;
		logic [15:0] crc;
	} cfr_entry_t;

endpackage

// File: rtl/cfr_stream_if.sv
// ----------------------------------------------------------------------------
// cfr_cmd_if / cfr_frame_if
// Valid/ready channels of the command framer: command bytes in, framed bytes
// out.
// ----------------------------------------------------------------------------
interface cfr_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] cmd_byte;
	logic       cmd_last;

	modport source (output valid, output cmd_byte, output cmd_last, input ready);
	modport sink   (input valid, input cmd_byte, input cmd_last, output ready);
endinterface

interface cfr_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// File: rtl/command_framer_crc16.sv
// ----------------------------------------------------------------------------
// command_framer_crc16
// Frames command lines for a serial link with an optional CRC-16/ARC trailer
// in upper-case hex, followed by a carriage return.
//
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    cmd_byte[7:0], cmd_last
//   frame    out  valid/ready    out_byte[7:0], out_last
//   apb      in   psel/penable   add_crc at address 0
//
// One command byte is taken per cycle while the 4-entry queue has room.
// The output register sends one byte per cycle while a byte is queued and
// frame.ready allows; a last byte is followed by the four hex CRC digits
// when add_crc is set, then by the CR. Accepted bytes reach it via the queue.
// arst_n clears the CRC, the queue and the output valid; add_crc resets to 1.
// A stalled frame channel fills the queue and then holds cmd.ready low.
// ----------------------------------------------------------------------------
module command_framer_crc16
	import cfr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	cfr_cmd_if.sink            cmd,
	cfr_frame_if.source        frame
);

	logic       add_crc_q;
	logic       reg_sel;
	logic       push_valid;
	logic       push_ready;
	cfr_entry_t push_data;
	logic       head_valid;
	cfr_entry_t head;
	logic       pop;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_ADD_CRC);
	assign prdata  = reg_sel ? {{(PDATA_W-1){1'b0}}, add_crc_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_crc_q <= 1'b1;
		end else if (psel && penable && pwrite && reg_sel) begin
			add_crc_q <= pwdata[0];
		end
	end

	cfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.add_crc    (add_crc_q),
		.cmd        (cmd),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	cfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (head_valid),
		.pop        (pop),
		.pop_data   (head)
	);

	cfr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.frame      (frame)
	);

endmodule

// File: rtl/cfr_front.sv
// ----------------------------------------------------------------------------
// cfr_front
// Accepts command bytes, substitutes colons for spaces when add_crc is set,
// runs the CRC-16/ARC and pushes one entry per byte, the last with the CRC.
// ----------------------------------------------------------------------------
module cfr_front
	import cfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        add_crc,
	cfr_cmd_if.sink     cmd,
	output logic        push_valid,
	input  logic        push_ready,
	output cfr_entry_t  push_data
);

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	logic [15:0] crc_acc_q;
	logic [7:0]  byte_sub;
	logic [15:0] crc_next;
	logic        accept;

	assign byte_sub = (add_crc && cmd.cmd_byte == CHAR_SPACE) ? CHAR_COLON : cmd.cmd_byte;
	assign crc_next = crc_step(crc_acc_q, byte_sub);
	assign accept   = cmd.valid && push_ready;

	assign cmd.ready      = push_ready;
	assign push_valid     = cmd.valid;
	assign push_data.data = byte_sub;
	assign push_data.last = cmd.cmd_last;
	assign push_data.hex  = add_crc;
	assign push_data.crc  = crc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_acc_q <= '0;
		end else if (accept) begin
			crc_acc_q <= cmd.cmd_last ? 16'h0000 : crc_next;
		end
	end

	// clear the CRC at the end of every frame
	a_crc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && cmd.cmd_last) |=> (crc_acc_q == 16'h0000))
		else $error("crc not cleared after last byte");

endmodule

// File: rtl/cfr_queue.sv
// ----------------------------------------------------------------------------
// cfr_queue
// Short queue of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module cfr_queue
	import cfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	output logic        push_ready,
	input  cfr_entry_t  push_data,
	output logic        pop_valid,
	input  logic        pop,
	output cfr_entry_t  pop_data
);

	cfr_entry_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (!do_push && do_pop) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_data;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count overflow");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("pop from empty queue");

endmodule

// File: rtl/cfr_back.sv
// ----------------------------------------------------------------------------
// cfr_back
// Emits each queued byte and, after the last byte of a command, the hex CRC
// when its hex flag is set and the carriage return, via a registered output.
// ----------------------------------------------------------------------------
module cfr_back
	import cfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  cfr_entry_t  head,
	output logic        pop,
	cfr_frame_if.source frame
);

	localparam logic [2:0] PH_BYTE = 3'd0;
	localparam logic [2:0] PH_HEX0 = 3'd1;
	localparam logic [2:0] PH_HEX1 = 3'd2;
	localparam logic [2:0] PH_HEX2 = 3'd3;
	localparam logic [2:0] PH_HEX3 = 3'd4;
	localparam logic [2:0] PH_CR   = 3'd5;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
	endfunction

	logic [2:0] phase_q;
	logic [2:0] phase_next;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic [7:0] sel_byte;
	logic       sel_last;
	logic       done;
	logic       advance;

	always_comb begin
		sel_byte   = CHAR_CR;
		sel_last   = 1'b0;
		phase_next = PH_BYTE;
		done       = 1'b0;
		unique case (phase_q)
			PH_BYTE: begin
				sel_byte = head.data;
				done     = !head.last;
				if (!head.last) phase_next = PH_BYTE;
				else if (head.hex) phase_next = PH_HEX0;
				else phase_next = PH_CR;
			end
			PH_HEX0: begin
				sel_byte   = hex_char(head.crc[15:12]);
				phase_next = PH_HEX1;
			end
			PH_HEX1: begin
				sel_byte   = hex_char(head.crc[11:8]);
				phase_next = PH_HEX2;
			end
			PH_HEX2: begin
				sel_byte   = hex_char(head.crc[7:4]);
				phase_next = PH_HEX3;
			end
			PH_HEX3: begin
				sel_byte   = hex_char(head.crc[3:0]);
				phase_next = PH_CR;
			end
			PH_CR: begin
				sel_byte   = CHAR_CR;
				sel_last   = 1'b1;
				phase_next = PH_BYTE;
				done       = 1'b1;
			end
			default: begin
				phase_next = PH_BYTE;
			end
		endcase
	end

	assign advance = head_valid && (!out_valid_q || frame.ready);
	assign pop     = advance && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_BYTE;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q     <= phase_next;
				out_valid_q <= 1'b1;
			end else if (frame.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= sel_byte;
			out_last_q <= sel_last;
		end
	end

	assign frame.valid    = out_valid_q;
	assign frame.out_byte = out_byte_q;
	assign frame.out_last = out_last_q;

	a_trailer_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_BYTE) |-> (head_valid && head.last))
		else $error("trailer phase without last byte at head");

	a_hex_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HEX0 || phase_q == PH_HEX1 || phase_q == PH_HEX2 ||
		 phase_q == PH_HEX3) |-> head.hex)
		else $error("hex digits without crc enabled");

	a_last_is_cr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (out_byte_q == CHAR_CR))
		else $error("frame end is not a carriage return");

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of command_framer_crc16. Command bytes go in over the cmd
// channel while the frame channel is drained with random backpressure. An
// in-bench framer computes the CRC-16/ARC, the colon substitution, the hex
// trailer and the carriage return for each accepted byte; every framed
// byte is compared with the oldest predicted one. add_crc is written and
// read back over APB between command bursts, also in the middle of a command.
// ----------------------------------------------------------------------------
module tb_top;
	import cfr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [PADDR_W-1:0] ADDR_ADD_CRC = PADDR_W'(4 * int'(REG_ADD_CRC));
	localparam logic [PADDR_W-1:0] ADDR_UNUSED  = PADDR_W'(4);
	localparam logic [7:0]         CHAR_ZERO    = 8'h30;
	localparam logic [7:0]         CHAR_UPPER_A = 8'h41;
	localparam int                 HOLD_CYCLES  = 200;
	localparam int                 DRAIN_CYCLES = 4;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} framed_byte_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	cfr_cmd_if   cmd_ch ();
	cfr_frame_if frame_ch ();

	command_framer_crc16 u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cmd     (cmd_ch),
		.frame   (frame_ch)
	);

	framed_byte_t framed_bytes_q[$];
	logic [15:0]  crc_run;
	logic         add_crc_m;
	int           err_cnt;
	logic         tx_idle_en;
	logic         rx_idle_en;
	logic         hold_req;
	logic         hold_seen;
	int           hold_left;
	int           gap_left;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin : run_limit
		#400000;
		$display("FAIL command_framer_crc16");
		$finish;
	end

	function automatic logic [15:0] crc16_arc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		return (nib < 4'd10) ? CHAR_ZERO + 8'(nib) : CHAR_UPPER_A + 8'(nib) - 8'd10;
	endfunction

	function automatic void queue_framed_byte(input logic [7:0] data, input logic last);
		framed_byte_t fb;
		fb.data = data;
		fb.last = last;
		framed_bytes_q.insert(framed_bytes_q.size(), fb);
	endfunction

	task automatic frame_command_byte(input logic [7:0] b, input logic last);
		logic [7:0] emitted;
		emitted = (add_crc_m && b == CHAR_SPACE) ? CHAR_COLON : b;
		crc_run = crc16_arc_byte(crc_run, emitted);
		queue_framed_byte(emitted, 1'b0);
		if (last) begin
			if (add_crc_m) begin
				for (int s = 12; s >= 0; s -= 4)
					queue_framed_byte(hex_char(crc_run[s +: 4]), 1'b0);
			end
			queue_framed_byte(CHAR_CR, 1'b1);
			crc_run = '0;
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		err_cnt++;
	endtask

	// checker: compare every framed transaction with the oldest prediction
	always @(posedge clk) begin
		framed_byte_t want;
		if (arst_n === 1'b1 && frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1) begin
			if (framed_bytes_q.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h last %b",
					frame_ch.out_byte, frame_ch.out_last));
			end else begin
				want = framed_bytes_q.pop_front();
				if (frame_ch.out_byte !== want.data)
					report_mismatch($sformatf("out_byte %02h, want %02h",
						frame_ch.out_byte, want.data));
				if (frame_ch.out_last !== want.last)
					report_mismatch($sformatf("out_last %b, want %b on byte %02h",
						frame_ch.out_last, want.last, want.data));
			end
		end
	end

	// frame sink: random ready bursts, plus a long hold-off on request
	initial begin : frame_sink
		frame_ch.ready <= 1'b0;
		hold_seen = 1'b0;
		hold_left = 0;
		gap_left  = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES - 1;
				frame_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left--;
				frame_ch.ready <= 1'b0;
			end else if (gap_left != 0) begin
				gap_left--;
				frame_ch.ready <= 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				gap_left = $urandom_range(0, 8);
				frame_ch.ready <= 1'b0;
			end else begin
				frame_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_cmd_byte(input logic [7:0] b, input logic last);
		if (tx_idle_en && $urandom_range(0, 4) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		cmd_ch.valid    <= 1'b1;
		cmd_ch.cmd_byte <= b;
		cmd_ch.cmd_last <= last;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		frame_command_byte(b, last);
	endtask

	task automatic drain_frames();
		cmd_ch.valid <= 1'b0;
		while (framed_bytes_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_ADD_CRC)
			add_crc_m = data[0];
		@(posedge clk);
	endtask

	task automatic apb_check_add_crc();
		logic [PDATA_W-1:0] rd;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_ADD_CRC;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== PDATA_W'(add_crc_m))
			report_mismatch($sformatf("add_crc reads %0h, want %0h", rd, add_crc_m));
	endtask

	task automatic set_add_crc(input logic val);
		apb_write(ADDR_ADD_CRC, PDATA_W'(val));
		apb_check_add_crc();
	endtask

	function automatic logic [7:0] pick_cmd_byte();
		case ($urandom_range(0, 3))
			0:       return CHAR_SPACE;
			1:       return 8'($urandom_range(0, 255));
			default: return 8'($urandom_range(8'h21, 8'h7E));
		endcase
	endfunction

	task automatic send_random_cmds(input int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			len = $urandom_range(1, 12);
			for (int i = 0; i < len; i++)
				send_cmd_byte(pick_cmd_byte(), i == len - 1);
			sent += len;
		end
	endtask

	task automatic test_reset_value();
		apb_check_add_crc();
	endtask

	task automatic test_field_extremes();
		send_cmd_byte(8'h00, 1'b1);
		send_cmd_byte(8'hFF, 1'b1);
		send_cmd_byte("A", 1'b0);
		send_cmd_byte(CHAR_SPACE, 1'b0);
		send_cmd_byte(CHAR_COLON, 1'b1);
		drain_frames();
	endtask

	task automatic test_crc_disabled();
		set_add_crc(1'b0);
		send_cmd_byte(CHAR_SPACE, 1'b0);
		send_cmd_byte("x", 1'b1);
		send_cmd_byte(8'hFF, 1'b1);
		drain_frames();
		apb_write(ADDR_UNUSED, PDATA_W'(1));
		apb_check_add_crc();
		send_cmd_byte(CHAR_SPACE, 1'b1);
		drain_frames();
	endtask

	task automatic test_switch_mid_command();
		set_add_crc(1'b1);
		send_cmd_byte("a", 1'b0);
		send_cmd_byte(CHAR_SPACE, 1'b0);
		drain_frames();
		set_add_crc(1'b0);
		send_cmd_byte(CHAR_SPACE, 1'b0);
		send_cmd_byte("b", 1'b1);
		send_cmd_byte("c", 1'b0);
		send_cmd_byte(CHAR_SPACE, 1'b0);
		drain_frames();
		set_add_crc(1'b1);
		send_cmd_byte(CHAR_SPACE, 1'b0);
		send_cmd_byte("d", 1'b1);
		drain_frames();
	endtask

	task automatic test_random_commands();
		for (int p = 0; p < 4; p++) begin
			set_add_crc(p[0]);
			send_random_cmds(30);
			drain_frames();
		end
	endtask

	task automatic test_backpressure();
		set_add_crc(1'b1);
		hold_req <= ~hold_req;
		send_random_cmds(24);
		drain_frames();
	endtask

	task automatic test_full_rate();
		tx_idle_en <= 1'b0;
		rx_idle_en <= 1'b0;
		set_add_crc(1'b0);
		send_random_cmds(12);
		drain_frames();
		set_add_crc(1'b1);
		send_random_cmds(18);
		drain_frames();
	endtask

	initial begin : main
		err_cnt   = 0;
		crc_run   = '0;
		add_crc_m = 1'b1;
		arst_n          <= 1'b0;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;
		cmd_ch.valid    <= 1'b0;
		cmd_ch.cmd_byte <= '0;
		cmd_ch.cmd_last <= 1'b0;
		tx_idle_en      <= 1'b1;
		rx_idle_en      <= 1'b1;
		hold_req        <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_value();
		test_field_extremes();
		test_crc_disabled();
		test_switch_mid_command();
		test_random_commands();
		test_backpressure();
		test_full_rate();

		if (err_cnt == 0)
			$display("PASS command_framer_crc16");
		else
			$display("FAIL command_framer_crc16");
		$finish;
	end

endmodule
